// File: hdl/dotq_pkg.sv
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared constants for the deadline ordered timer queue: field widths, a
// per-request result limit, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dotq_pkg;

  // Field widths of a deadline, of a reported handle and of a status code.
  localparam int SEC_W        = 32;
  localparam int NSEC_W       = 30;
  localparam int KEY_W        = SEC_W + NSEC_W;
  localparam int HANDLE_OUT_W = 32;
  localparam int STATUS_W     = 2;

  // At most this many handles are removed by one expire request.
  localparam int MAX_RESULTS = 16;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: hdl/dotq_ram.sv
// ----------------------------------------------------------------------------
// dotq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/deadline_ordered_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_unit
// Queue of pending timed actions kept sorted by deadline in a circular RAM.
// Insert walks from the tail towards the head, moving later entries up one
// place; expire pops the head group and reports the new head deadline.
// ----------------------------------------------------------------------------
// Channel  | Handshake              | Payload
// request  | start in, busy out     | opcode, deadline_sec, deadline_nsec,
//          |                        | action_handle
// result   | result_valid out       | status, fired_handle, last_fired,
//          |                        | rearm_needed, queue_nonempty, next_sec,
//          |                        | next_nsec
//
// Every entry visited takes a RAM read step and a compare step, because the
// RAM read data is registered. An insert stays busy while it walks past each
// entry with a later deadline and writes the new entry; an expire stays busy
// while it reads each entry of the group and, unless it empties the queue,
// the entry after it. Queue full and queue empty answers never raise busy
// and come in the cycle after the request. Reset empties the queue at once.
// Results are shown for one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_ordered_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [31:0] deadline_sec,
  input  wire logic [29:0] deadline_nsec,
  input  wire logic [31:0] action_handle,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [31:0]      fired_handle,
  output logic             last_fired,
  output logic             rearm_needed,
  output logic             queue_nonempty,
  output logic [31:0]      next_sec,
  output logic [29:0]      next_nsec
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W   = dotq_pkg::KEY_W;
  localparam int ENTRY_W = KEY_W + HANDLE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IRD  = 3'd1;
  localparam logic [2:0] S_IDAT = 3'd2;
  localparam logic [2:0] S_ERD  = 3'd3;
  localparam logic [2:0] S_EDAT = 3'd4;
  localparam logic [2:0] S_EFIN = 3'd5;

  logic [2:0]             state;
  logic [CNT_W-1:0]       count;
  logic [ADDR_W-1:0]      head;
  logic [KEY_W-1:0]       head_key;
  logic [CNT_W-1:0]       idx;
  logic [KEY_W-1:0]       req_key;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [HANDLE_BITS-1:0] pend_handle;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [63:0]            in_handle_ext;
  logic [63:0]            pend_ext;
  logic                   in_group;
  logic [CNT_W-1:0]       idx_inc;

  // Maps a place in the queue to a RAM address, wrapping once at the depth.
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [CNT_W-1:0]  ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  dotq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry fields and handle width conversions.
  assign rd_key        = ram_rdata[ENTRY_W-1:HANDLE_BITS];
  assign rd_handle     = ram_rdata[HANDLE_BITS-1:0];
  assign in_handle_ext = {32'd0, action_handle};
  assign pend_ext      = 64'(pend_handle);
  assign idx_inc       = idx + CNT_W'(1);
  assign busy          = (state != S_IDLE);

  // Entries with the head deadline form the group, up to the per-request limit.
  assign in_group = (int'(idx) < dotq_pkg::MAX_RESULTS) &&
                    ((idx == '0) || (rd_key == head_key));

  // RAM access for the current step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head, idx);
    ram_wdata = {req_key, req_handle};
    ram_raddr = phys(head, idx);
    case (state)
      S_IRD: begin
        if (idx == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = phys(head, idx - CNT_W'(1));
        end
      end
      S_IDAT: begin
        ram_we = 1'b1;
        if (rd_key > req_key) begin
          ram_wdata = ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      head         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_key    <= {deadline_sec, deadline_nsec};
            req_handle <= in_handle_ext[HANDLE_BITS-1:0];
            idx        <= '0;
            if (opcode == dotq_pkg::OP_INSERT) begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                result_valid   <= 1'b1;
                status         <= dotq_pkg::STATUS_FULL;
                fired_handle   <= '0;
                last_fired     <= 1'b1;
                rearm_needed   <= 1'b0;
                queue_nonempty <= 1'b1;
                next_sec       <= head_key[KEY_W-1:dotq_pkg::NSEC_W];
                next_nsec      <= head_key[dotq_pkg::NSEC_W-1:0];
              end else begin
                idx   <= count;
                state <= S_IRD;
              end
            end else begin
              if (count == '0) begin
                result_valid   <= 1'b1;
                status         <= dotq_pkg::STATUS_EMPTY;
                fired_handle   <= '0;
                last_fired     <= 1'b1;
                rearm_needed   <= 1'b0;
                queue_nonempty <= 1'b0;
                next_sec       <= '0;
                next_nsec      <= '0;
              end else begin
                state <= S_ERD;
              end
            end
          end
        end
        S_IRD: begin
          if (idx == '0) begin
            // The new entry lands at the head.
            head_key       <= req_key;
            count          <= count + CNT_W'(1);
            result_valid   <= 1'b1;
            status         <= dotq_pkg::STATUS_OK;
            fired_handle   <= '0;
            last_fired     <= 1'b1;
            rearm_needed   <= 1'b1;
            queue_nonempty <= 1'b1;
            next_sec       <= req_key[KEY_W-1:dotq_pkg::NSEC_W];
            next_nsec      <= req_key[dotq_pkg::NSEC_W-1:0];
            state          <= S_IDLE;
          end else begin
            state <= S_IDAT;
          end
        end
        S_IDAT: begin
          if (rd_key > req_key) begin
            // Later entry moved up one place; keep walking towards the head.
            idx   <= idx - CNT_W'(1);
            state <= S_IRD;
          end else begin
            count          <= count + CNT_W'(1);
            result_valid   <= 1'b1;
            status         <= dotq_pkg::STATUS_OK;
            fired_handle   <= '0;
            last_fired     <= 1'b1;
            rearm_needed   <= 1'b0;
            queue_nonempty <= 1'b1;
            next_sec       <= head_key[KEY_W-1:dotq_pkg::NSEC_W];
            next_nsec      <= head_key[dotq_pkg::NSEC_W-1:0];
            state          <= S_IDLE;
          end
        end
        S_ERD: begin
          state <= S_EDAT;
        end
        S_EDAT: begin
          if (in_group) begin
            // The previous member is now known not to be the last one.
            if (idx != '0) begin
              result_valid   <= 1'b1;
              status         <= dotq_pkg::STATUS_OK;
              fired_handle   <= pend_ext[31:0];
              last_fired     <= 1'b0;
              rearm_needed   <= 1'b0;
              queue_nonempty <= 1'b0;
              next_sec       <= '0;
              next_nsec      <= '0;
            end
            pend_handle <= rd_handle;
            idx         <= idx_inc;
            state       <= (idx_inc < count) ? S_ERD : S_EFIN;
          end else begin
            // This entry ends the group and becomes the new head.
            head           <= phys(head, idx);
            count          <= count - idx;
            head_key       <= rd_key;
            result_valid   <= 1'b1;
            status         <= dotq_pkg::STATUS_OK;
            fired_handle   <= pend_ext[31:0];
            last_fired     <= 1'b1;
            rearm_needed   <= 1'b1;
            queue_nonempty <= 1'b1;
            next_sec       <= rd_key[KEY_W-1:dotq_pkg::NSEC_W];
            next_nsec      <= rd_key[dotq_pkg::NSEC_W-1:0];
            state          <= S_IDLE;
          end
        end
        S_EFIN: begin
          // The whole queue expired.
          head           <= phys(head, idx);
          count          <= '0;
          result_valid   <= 1'b1;
          status         <= dotq_pkg::STATUS_OK;
          fired_handle   <= pend_ext[31:0];
          last_fired     <= 1'b1;
          rearm_needed   <= 1'b0;
          queue_nonempty <= 1'b0;
          next_sec       <= '0;
          next_nsec      <= '0;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/dotq_checker.sv
// ----------------------------------------------------------------------------
// dotq_checker
// Port level checks for the deadline ordered timer queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid,
  input wire logic [1:0]  status,
  input wire logic        last_fired,
  input wire logic        rearm_needed,
  input wire logic        queue_nonempty
);

  // Reset leaves the block idle with nothing on the result port.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

  // An accepted request is either worked on or answered at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("accepted request neither started nor answered");

  // Error answers are always single and final.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != dotq_pkg::STATUS_OK |-> last_fired)
    else $error("error result not marked last");

  // Only the final result of a request carries head information.
  a_mid_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_fired |-> !rearm_needed && !queue_nonempty)
    else $error("non-final result carries head information");

  // An empty queue answer reports no remaining actions.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == dotq_pkg::STATUS_EMPTY |-> !queue_nonempty)
    else $error("empty answer claims remaining actions");

endmodule

bind deadline_ordered_timer_queue_unit dotq_checker u_dotq_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .result_valid   (result_valid),
  .status         (status),
  .last_fired     (last_fired),
  .rearm_needed   (rearm_needed),
  .queue_nonempty (queue_nonempty)
);

`default_nettype wire
